@@ rtl/core/bqd_pkg.sv @@
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared constants, register map, operation codes and control types of the
// biquad filter unit.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int CFG_ADDR_W      = 6;
  localparam int CFG_DATA_W      = 64;
  localparam int REG_STRIDE_BITS = 3;
  localparam int REG_IDX_W       = CFG_ADDR_W - REG_STRIDE_BITS;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B0     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B1     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B2     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A1     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A2     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd6;

  localparam int COEF_W    = 32;
  localparam int GAIN_W    = 40;
  localparam int COEF_FRAC = 30;
  localparam int FRAC_BITS = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 40'd65536;

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_PRESET = 2'd2;

  // Multiplier operands are 33-bit signed chunks; operands wider than one
  // chunk are split into a low and a high half.
  localparam int CHUNK  = 32;
  localparam int EXT_W  = 64;
  localparam int MUL_W  = CHUNK + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FULL_W = PROD_W + CHUNK;

  typedef enum logic [1:0] {
    SRC_D1,
    SRC_D2,
    SRC_W,
    SRC_X
  } a_src_t;

  typedef enum logic [2:0] {
    CSEL_B0,
    CSEL_B1,
    CSEL_B2,
    CSEL_A1,
    CSEL_A2,
    CSEL_GAIN
  } c_sel_t;

  typedef enum logic [1:0] {
    DST_PRESET,
    DST_W_SUB,
    DST_Y_LOAD,
    DST_Y_ADD
  } dest_t;

  typedef struct packed {
    logic   valid;
    logic   hi;
    a_src_t a_src;
    c_sel_t c_sel;
    dest_t  dest;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load_x;
    logic clear;
    logic shift;
    logic load_out;
    logic pass;
  } dp_cmd_t;

  typedef struct packed {
    logic              enable;
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRE_LO,
    ST_PRE_HI,
    ST_PRE_WAIT,
    ST_A1_LO,
    ST_A1_HI,
    ST_A2_LO,
    ST_A2_HI,
    ST_W_WAIT,
    ST_B0_LO,
    ST_B0_HI,
    ST_B1_LO,
    ST_B1_HI,
    ST_B2_LO,
    ST_B2_HI,
    ST_DRAIN,
    ST_OUT
  } ctrl_state_t;

endpackage

@@ rtl/core/bqd_if.sv @@
// ----------------------------------------------------------------------------
// Biquad filter channels
// Valid/ready interfaces for the sample input and the filtered output.
// ----------------------------------------------------------------------------
interface bqd_sample_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output operation, output sample_value, input ready);
  modport sink (input valid, input operation, input sample_value, output ready);
endinterface

interface bqd_result_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink (input valid, input filtered_value, output ready);
endinterface

@@ rtl/core/bqd_regs.sv @@
// ----------------------------------------------------------------------------
// Biquad filter registers
// APB register file holding the enable, the five coefficients and the
// preset gain.
// ----------------------------------------------------------------------------
module bqd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bqd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bqd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bqd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output bqd_pkg::cfg_t                  cfg
);
  import bqd_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[CFG_ADDR_W-1:REG_STRIDE_BITS];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.b0     <= '0;
      cfg.b1     <= '0;
      cfg.b2     <= '0;
      cfg.a1     <= '0;
      cfg.a2     <= '0;
      cfg.gain   <= GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_B0:     cfg.b0     <= pwdata[COEF_W-1:0];
        REG_B1:     cfg.b1     <= pwdata[COEF_W-1:0];
        REG_B2:     cfg.b2     <= pwdata[COEF_W-1:0];
        REG_A1:     cfg.a1     <= pwdata[COEF_W-1:0];
        REG_A2:     cfg.a2     <= pwdata[COEF_W-1:0];
        REG_GAIN:   cfg.gain   <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE: prdata = CFG_DATA_W'(cfg.enable);
      REG_B0:     prdata = CFG_DATA_W'($signed(cfg.b0));
      REG_B1:     prdata = CFG_DATA_W'($signed(cfg.b1));
      REG_B2:     prdata = CFG_DATA_W'($signed(cfg.b2));
      REG_A1:     prdata = CFG_DATA_W'($signed(cfg.a1));
      REG_A2:     prdata = CFG_DATA_W'($signed(cfg.a2));
      REG_GAIN:   prdata = CFG_DATA_W'(cfg.gain);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/bqd_datapath.sv @@
// ----------------------------------------------------------------------------
// Biquad filter datapath
// Shared multiplier with accumulate, round and saturate stages, and the
// filter state it updates under command of the sequencer.
// ----------------------------------------------------------------------------
module bqd_datapath #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bqd_pkg::cfg_t                 cfg,
  input  bqd_pkg::dp_cmd_t              cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                          busy,
  output logic signed [SAMPLE_BITS-1:0] filtered_value
);
  import bqd_pkg::*;

  localparam int OUT_W = EXT_W + 1;

  localparam logic signed [FULL_W-1:0] ST_MAX =
    {{(FULL_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [FULL_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [STATE_BITS:0] SN_MAX = {2'b00, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS:0] SN_MIN = ~SN_MAX;
  localparam logic signed [OUT_W-1:0] O_MAX =
    {{(OUT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] O_MIN = ~O_MAX;
  localparam logic signed [FULL_W-1:0] COEF_HALF =
    {{(FULL_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_HALF =
    {{(OUT_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  function automatic logic signed [STATE_BITS-1:0] sat_wide(
    input logic signed [FULL_W-1:0] v
  );
    logic signed [STATE_BITS-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[STATE_BITS-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_narrow(
    input logic signed [STATE_BITS:0] v
  );
    logic signed [STATE_BITS-1:0] r;
    if (v > SN_MAX) begin
      r = SN_MAX[STATE_BITS-1:0];
    end else if (v < SN_MIN) begin
      r = SN_MIN[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

  logic signed [STATE_BITS-1:0]  d1;
  logic signed [STATE_BITS-1:0]  d2;
  logic signed [STATE_BITS-1:0]  w;
  logic signed [STATE_BITS-1:0]  y;
  logic signed [STATE_BITS-1:0]  term;
  logic signed [SAMPLE_BITS-1:0] x_reg;

  logic signed [EXT_W-1:0]  a_ext;
  logic signed [COEF_W-1:0] coef;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] part;
  logic signed [FULL_W-1:0] full;
  logic signed [OUT_W-1:0]  y_round;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  uop_t ctl1;
  uop_t ctl2;
  uop_t ctl3;

  always_comb begin
    unique case (cmd.uop.a_src)
      SRC_D1: a_ext = EXT_W'(d1);
      SRC_D2: a_ext = EXT_W'(d2);
      SRC_W:  a_ext = EXT_W'(w);
      SRC_X:  a_ext = EXT_W'(x_reg);
    endcase
  end

  always_comb begin
    unique case (cmd.uop.c_sel)
      CSEL_B0: coef = $signed(cfg.b0);
      CSEL_B1: coef = $signed(cfg.b1);
      CSEL_B2: coef = $signed(cfg.b2);
      CSEL_A1: coef = $signed(cfg.a1);
      CSEL_A2: coef = $signed(cfg.a2);
      default: coef = '0;
    endcase
  end

  // A preset multiplies the sample by the two halves of the gain; a
  // coefficient term multiplies the two halves of the state by the
  // coefficient.
  always_comb begin
    if (cmd.uop.c_sel == CSEL_GAIN) begin
      mul_a = MUL_W'(x_reg);
      if (cmd.uop.hi) begin
        mul_b = $signed({{(MUL_W-GAIN_W+CHUNK){1'b0}}, cfg.gain[GAIN_W-1:CHUNK]});
      end else begin
        mul_b = $signed({1'b0, cfg.gain[CHUNK-1:0]});
      end
    end else begin
      if (cmd.uop.hi) begin
        mul_a = $signed({a_ext[EXT_W-1], a_ext[EXT_W-1:CHUNK]});
      end else begin
        mul_a = $signed({1'b0, a_ext[CHUNK-1:0]});
      end
      mul_b = MUL_W'(coef);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctl1.valid && !ctl1.hi) begin
      part <= prod;
    end
    if (ctl1.valid && ctl1.hi) begin
      full <= FULL_W'(part) + (FULL_W'(prod) <<< CHUNK);
    end
    if (ctl2.c_sel == CSEL_GAIN) begin
      term <= sat_wide(full);
    end else begin
      term <= sat_wide((full + COEF_HALF) >>> COEF_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl1       <= cmd.uop;
      ctl2       <= ctl1;
      ctl2.valid <= ctl1.valid && ctl1.hi;
      ctl3       <= ctl2;
    end
  end

  assign busy = ctl1.valid || ctl2.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (cmd.clear) begin
      d1 <= '0;
      d2 <= '0;
    end else if (cmd.shift) begin
      d2 <= d1;
      d1 <= w;
    end else if (ctl3.valid && ctl3.dest == DST_PRESET) begin
      d1 <= term;
      d2 <= term;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_reg <= sample_value;
      w     <= sat_wide(FULL_W'(sample_value) <<< FRAC_BITS);
    end else if (ctl3.valid && ctl3.dest == DST_W_SUB) begin
      w <= sat_narrow((STATE_BITS+1)'(w) - (STATE_BITS+1)'(term));
    end
    if (ctl3.valid && ctl3.dest == DST_Y_LOAD) begin
      y <= term;
    end else if (ctl3.valid && ctl3.dest == DST_Y_ADD) begin
      y <= sat_narrow((STATE_BITS+1)'(y) + (STATE_BITS+1)'(term));
    end
  end

  always_comb begin
    y_round = (OUT_W'(y) + OUT_HALF) >>> FRAC_BITS;
    if (y_round > O_MAX) begin
      y_sat = O_MAX[SAMPLE_BITS-1:0];
    end else if (y_round < O_MIN) begin
      y_sat = O_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_round[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_value <= cmd.pass ? x_reg : y_sat;
    end
  end

endmodule

@@ rtl/core/bqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Biquad filter sequencer
// Accepts transactions, issues the multiply steps of each filter or preset to
// the shared datapath and hands each filter result to the output register.
// ----------------------------------------------------------------------------
module bqd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             filter_enable,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       operation,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             busy,
  output bqd_pkg::dp_cmd_t cmd
);
  import bqd_pkg::*;

  function automatic uop_t make_uop(input a_src_t a, input c_sel_t c, input dest_t d,
                                    input logic hi);
    uop_t u;
    u.valid = 1'b1;
    u.hi    = hi;
    u.a_src = a;
    u.c_sel = c;
    u.dest  = d;
    return u;
  endfunction

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        primed;
  logic        primed_next;
  logic        job_filter;
  logic        job_filter_next;
  logic        pass;
  logic        pass_next;
  logic        out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      primed     <= 1'b0;
      job_filter <= 1'b0;
      pass       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      primed     <= primed_next;
      job_filter <= job_filter_next;
      pass       <= pass_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    primed_next     = primed;
    job_filter_next = job_filter;
    pass_next       = pass;
    out_valid_next  = out_valid && !out_ready;
    cmd             = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (operation)
            OP_CLEAR: begin
              cmd.clear   = 1'b1;
              primed_next = 1'b0;
            end
            OP_PRESET: begin
              cmd.load_x      = 1'b1;
              job_filter_next = 1'b0;
              state_next      = ST_PRE_LO;
            end
            OP_FILTER: begin
              cmd.load_x = 1'b1;
              if (!filter_enable) begin
                pass_next  = 1'b1;
                state_next = ST_OUT;
              end else begin
                pass_next       = 1'b0;
                job_filter_next = 1'b1;
                state_next      = primed ? ST_A1_LO : ST_PRE_LO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRE_LO: begin
        cmd.uop    = make_uop(SRC_X, CSEL_GAIN, DST_PRESET, 1'b0);
        state_next = ST_PRE_HI;
      end
      ST_PRE_HI: begin
        cmd.uop    = make_uop(SRC_X, CSEL_GAIN, DST_PRESET, 1'b1);
        state_next = ST_PRE_WAIT;
      end
      ST_PRE_WAIT: begin
        if (!busy) begin
          primed_next = 1'b1;
          state_next  = job_filter ? ST_A1_LO : ST_IDLE;
        end
      end
      ST_A1_LO: begin
        cmd.uop    = make_uop(SRC_D1, CSEL_A1, DST_W_SUB, 1'b0);
        state_next = ST_A1_HI;
      end
      ST_A1_HI: begin
        cmd.uop    = make_uop(SRC_D1, CSEL_A1, DST_W_SUB, 1'b1);
        state_next = ST_A2_LO;
      end
      ST_A2_LO: begin
        cmd.uop    = make_uop(SRC_D2, CSEL_A2, DST_W_SUB, 1'b0);
        state_next = ST_A2_HI;
      end
      ST_A2_HI: begin
        cmd.uop    = make_uop(SRC_D2, CSEL_A2, DST_W_SUB, 1'b1);
        state_next = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        if (!busy) begin
          state_next = ST_B0_LO;
        end
      end
      ST_B0_LO: begin
        cmd.uop    = make_uop(SRC_W, CSEL_B0, DST_Y_LOAD, 1'b0);
        state_next = ST_B0_HI;
      end
      ST_B0_HI: begin
        cmd.uop    = make_uop(SRC_W, CSEL_B0, DST_Y_LOAD, 1'b1);
        state_next = ST_B1_LO;
      end
      ST_B1_LO: begin
        cmd.uop    = make_uop(SRC_D1, CSEL_B1, DST_Y_ADD, 1'b0);
        state_next = ST_B1_HI;
      end
      ST_B1_HI: begin
        cmd.uop    = make_uop(SRC_D1, CSEL_B1, DST_Y_ADD, 1'b1);
        state_next = ST_B2_LO;
      end
      ST_B2_LO: begin
        cmd.uop    = make_uop(SRC_D2, CSEL_B2, DST_Y_ADD, 1'b0);
        state_next = ST_B2_HI;
      end
      ST_B2_HI: begin
        cmd.uop    = make_uop(SRC_D2, CSEL_B2, DST_Y_ADD, 1'b1);
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) begin
          cmd.shift  = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          cmd.pass       = pass;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/biquad_iir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Biquad IIR filter unit
// Direct-form-II biquad with APB configuration and valid/ready channels.
// ----------------------------------------------------------------------------
// Every product passes twice through one 33 by 33 bit multiplier, followed by
// accumulate, round-and-saturate and combine stages. A filtered sample issues
// its five coefficient terms in sequence, and the multiplier pipeline drains
// before the new internal value and the result are used; when it is the first
// sample after a clear, the delay elements are preset first. A preset
// transaction only presets the delay elements, a clear zeroes them and a
// pass-through sample with filtering disabled goes straight to the output
// register. No new transaction is taken until the current one is through.
// The result sits in an output register, so a new transaction is taken while
// it waits to be collected.
module biquad_iir_filter_unit #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bqd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bqd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bqd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  bqd_sample_if.sink                     sample_in,
  bqd_result_if.source                   result_out
);
  import bqd_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  logic    busy;

  bqd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bqd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .filter_enable (cfg.enable),
    .in_valid      (sample_in.valid),
    .in_ready      (sample_in.ready),
    .operation     (sample_in.operation),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .busy          (busy),
    .cmd           (cmd)
  );

  bqd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sample_value   (sample_in.sample_value),
    .busy           (busy),
    .filtered_value (result_out.filtered_value)
  );

endmodule

@@ rtl/core/bqd_checker.sv @@
// ----------------------------------------------------------------------------
// Biquad filter checker
// Port-level assertions on the sequencing of the biquad filter unit.
// ----------------------------------------------------------------------------
module bqd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [1:0]             operation,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] filtered_value
);
  import bqd_pkg::*;

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_FILTER || operation == OP_PRESET))
    |=> !in_ready)
    else $error("input still ready after a filter or preset transaction");

  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation != OP_FILTER && operation != OP_PRESET)
    |=> in_ready)
    else $error("input not ready after a clear or ignored transaction");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in progress");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(filtered_value)))
    else $error("stalled result changed or was dropped");

endmodule

bind biquad_iir_filter_unit bqd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bqd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (sample_in.valid),
  .in_ready       (sample_in.ready),
  .operation      (sample_in.operation),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .filtered_value (result_out.filtered_value)
);

@@ sim/tb_biquad_iir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the biquad IIR filter unit
// Drives sample, clear and preset transactions through the valid/ready input
// channel and checks every filtered output against a bit-accurate fixed-point
// predictor, or a table value for known directed rows. A short table covers
// pass-through, unity and saturating gains, clears, presets and unused codes.
// Random phases then follow under changing coefficient sets and back-pressure
// patterns, with coefficients rewritten over APB while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_biquad_iir_filter_unit;
  import bqd_pkg::*;

  localparam int SAMPLE_BITS     = 24;
  localparam int STATE_BITS      = 48;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 500;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int PRESSURE_PHASE  = 6;
  localparam int DIRECTED_COUNT  = 27;
  localparam int unsigned LIMIT_NS = 5_000_000;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [127:0]           wide_t;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  typedef struct {
    logic [1:0] op;
    sample_t    value;
    int         cfg_id;
    bit         known;
    sample_t    result;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bqd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
  bqd_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_if ();

  biquad_iir_filter_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .STATE_BITS (STATE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sample_in (smp_if),
    .result_out(res_if)
  );

  cfg_t        shadow_cfg;
  state_t      tap_one    = '0;
  state_t      tap_two    = '0;
  bit          tap_primed = 1'b0;
  sample_t     expected_samples[$];
  int          mismatches    = 0;
  int          holds_asked   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{OP_FILTER, SAMPLE_MAX,      0, 1'b1, SAMPLE_MAX},
    '{OP_FILTER, SAMPLE_MIN,      0, 1'b1, SAMPLE_MIN},
    '{OP_FILTER, 24'sd0,          0, 1'b1, 24'sd0},
    '{OP_FILTER, -24'sd1,         0, 1'b1, -24'sd1},
    '{OP_CLEAR,  24'sd0,          0, 1'b0, 24'sd0},
    '{OP_PRESET, 24'sd12345,      0, 1'b0, 24'sd0},
    '{OP_UNUSED, 24'sd5,          0, 1'b0, 24'sd0},
    '{OP_FILTER, 24'sh2AAAAA,     0, 1'b1, 24'sh2AAAAA},
    '{OP_FILTER, SAMPLE_MAX,      1, 1'b1, SAMPLE_MAX},
    '{OP_FILTER, SAMPLE_MIN,      1, 1'b1, SAMPLE_MIN},
    '{OP_FILTER, 24'sd1,          1, 1'b1, 24'sd1},
    '{OP_FILTER, SAMPLE_MAX,      2, 1'b1, SAMPLE_MAX},
    '{OP_FILTER, SAMPLE_MIN,      2, 1'b1, SAMPLE_MIN},
    '{OP_FILTER, 24'sd1000,       3, 1'b0, 24'sd0},
    '{OP_FILTER, SAMPLE_MAX,      3, 1'b0, 24'sd0},
    '{OP_FILTER, SAMPLE_MIN,      3, 1'b0, 24'sd0},
    '{OP_CLEAR,  24'sd77,         3, 1'b0, 24'sd0},
    '{OP_FILTER, -24'sd4000,      3, 1'b0, 24'sd0},
    '{OP_FILTER, 24'sd0,          3, 1'b0, 24'sd0},
    '{OP_PRESET, SAMPLE_MAX,      3, 1'b0, 24'sd0},
    '{OP_FILTER, 24'sd100,        3, 1'b0, 24'sd0},
    '{OP_UNUSED, -24'sd1,         3, 1'b0, 24'sd0},
    '{OP_FILTER, 24'sd200,        3, 1'b0, 24'sd0},
    '{OP_PRESET, SAMPLE_MIN,      4, 1'b0, 24'sd0},
    '{OP_FILTER, SAMPLE_MAX,      4, 1'b0, 24'sd0},
    '{OP_CLEAR,  24'sd0,          4, 1'b0, 24'sd0},
    '{OP_FILTER, SAMPLE_MIN,      4, 1'b0, 24'sd0}
  };

  function automatic state_t clamp_state(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (STATE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return state_t'(hi);
    if (v < lo) return state_t'(lo);
    return state_t'(v);
  endfunction

  function automatic state_t sat_sum(state_t a, state_t b, bit subtract);
    wide_t aw;
    wide_t bw;
    aw = a;
    bw = b;
    return clamp_state(subtract ? aw - bw : aw + bw);
  endfunction

  function automatic state_t scaled_term(state_t d, logic [COEF_W-1:0] c);
    wide_t dw;
    wide_t cw;
    dw = d;
    cw = $signed(c);
    return clamp_state((dw * cw + (wide_t'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
  endfunction

  function automatic state_t preset_level(sample_t x);
    wide_t xw;
    wide_t gw;
    xw = x;
    gw = shadow_cfg.gain;
    return clamp_state(xw * gw);
  endfunction

  function automatic bit compute_biquad(logic [1:0] op, sample_t x, output sample_t y);
    state_t w0;
    state_t acc;
    wide_t  xw;
    wide_t  q;
    wide_t  omax;
    y = '0;
    case (op)
      OP_CLEAR: begin
        tap_one = '0;
        tap_two = '0;
        tap_primed = 1'b0;
        return 1'b0;
      end
      OP_PRESET: begin
        tap_one = preset_level(x);
        tap_two = tap_one;
        tap_primed = 1'b1;
        return 1'b0;
      end
      OP_FILTER: begin
        if (!shadow_cfg.enable) begin
          y = x;
          return 1'b1;
        end
        if (!tap_primed) begin
          tap_one = preset_level(x);
          tap_two = tap_one;
          tap_primed = 1'b1;
        end
        xw = x;
        w0 = clamp_state(xw <<< FRAC_BITS);
        w0 = sat_sum(w0, scaled_term(tap_one, shadow_cfg.a1), 1'b1);
        w0 = sat_sum(w0, scaled_term(tap_two, shadow_cfg.a2), 1'b1);
        acc = sat_sum(scaled_term(w0, shadow_cfg.b0), scaled_term(tap_one, shadow_cfg.b1), 1'b0);
        acc = sat_sum(acc, scaled_term(tap_two, shadow_cfg.b2), 1'b0);
        tap_two = tap_one;
        tap_one = w0;
        xw = acc;
        q = (xw + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        omax = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (q > omax) q = omax;
        if (q < -omax - 1) q = -omax - 1;
        y = sample_t'(q);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic cfg_t directed_config(int id);
    cfg_t c;
    c = '{enable: 1'b1, b0: '0, b1: '0, b2: '0, a1: '0, a2: '0, gain: GAIN_RESET};
    case (id)
      1: c.b0 = 32'h4000_0000;
      2: c.b0 = 32'h7FFF_FFFF;
      3: begin
        c.b0 = 32'h0800_0000;
        c.b1 = 32'h1000_0000;
        c.b2 = 32'h0800_0000;
        c.a1 = 32'hB000_0000;
        c.a2 = 32'h1999_999A;
        c.gain = 40'd436907;
      end
      4: begin
        c.b0 = 32'h8000_0000;
        c.b1 = 32'h8000_0000;
        c.b2 = 32'h8000_0000;
        c.a1 = 32'h8000_0000;
        c.a2 = 32'h8000_0000;
        c.gain = '1;
      end
      default: c.enable = 1'b0;
    endcase
    return c;
  endfunction

  function automatic cfg_t stable_config();
    cfg_t    c;
    int      a2;
    longint  lim;
    longint  a1;
    longint  den;
    c.enable = 1'b1;
    c.b0 = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    c.b1 = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    c.b2 = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    a2 = int'($urandom_range(0, 1932735282)) - 966367641;
    lim = ((longint'(1) << 30) + a2) * 95 / 100;
    a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    c.a1 = a1[31:0];
    c.a2 = a2;
    den = (longint'(1) << 30) + a1 + a2;
    c.gain = GAIN_W'((longint'(1) << 46) / den);
    return c;
  endfunction

  function automatic cfg_t phase_config(int phase);
    cfg_t c;
    c = '{enable: 1'b1, b0: $urandom(), b1: $urandom(), b2: $urandom(),
          a1: $urandom(), a2: $urandom(), gain: {8'($urandom()), 32'($urandom())}};
    case (phase)
      3: c.enable = 1'b0;
      4: begin
        c.b0 = 32'h7FFF_FFFF;
        c.b1 = 32'h7FFF_FFFF;
        c.b2 = 32'h7FFF_FFFF;
        c.a1 = 32'h7FFF_FFFF;
        c.a2 = 32'h7FFF_FFFF;
        c.gain = '0;
      end
      7: c.gain = '1;
      2: ;
      default: c = stable_config();
    endcase
    return c;
  endfunction

  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return SAMPLE_MAX;
    if (r < 10) return SAMPLE_MIN;
    if (r < 50) return sample_t'($urandom());
    return sample_t'(int'($urandom_range(131072)) - 65536);
  endfunction

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_STRIDE_BITS;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    cfg_write(REG_ENABLE, CFG_DATA_W'(c.enable));
    cfg_write(REG_B0, {{32{c.b0[31]}}, c.b0});
    cfg_write(REG_B1, {{32{c.b1[31]}}, c.b1});
    cfg_write(REG_B2, {{32{c.b2[31]}}, c.b2});
    cfg_write(REG_A1, {{32{c.a1[31]}}, c.a1});
    cfg_write(REG_A2, {{32{c.a2[31]}}, c.a2});
    cfg_write(REG_GAIN, CFG_DATA_W'(c.gain));
    shadow_cfg = c;
  endtask

  task automatic wait_for_idle();
    smp_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] op, sample_t value, bit known, sample_t typed);
    sample_t predicted;
    bit      has_result;
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid        <= 1'b1;
    smp_if.operation    <= op;
    smp_if.sample_value <= value;
    do @(posedge clk); while (!smp_if.ready);
    has_result = compute_biquad(op, value, predicted);
    if (has_result) expected_samples.push_back(known ? typed : predicted);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 65; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 65; end
      default: begin send_idle_pct = 9; stall_pct = 9; end
    endcase
  endtask

  function automatic void note_mismatch(string what, sample_t want, sample_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int        hold_left;
    int        holds_taken;
    hold_left = 0;
    holds_taken = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_taken != holds_asked) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    sample_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (expected_samples.size() == 0) begin
          note_mismatch("result with no transaction pending", '0, res_if.filtered_value);
        end else begin
          want = expected_samples.pop_front();
          if (res_if.filtered_value !== want)
            note_mismatch("filtered_value mismatch", want, res_if.filtered_value);
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS * 1ns);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          cur_cfg;
    int          counted;
    int unsigned r;
    logic [1:0]  op;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    smp_if.valid        <= 1'b0;
    smp_if.operation    <= OP_FILTER;
    smp_if.sample_value <= '0;
    shadow_cfg = '{enable: 1'b0, b0: '0, b1: '0, b2: '0, a1: '0, a2: '0, gain: GAIN_RESET};
    cur_cfg = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle_mode(3);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_id != cur_cfg) begin
        wait_for_idle();
        if (directed_rows[i].cfg_id == 1) cfg_write(REG_SPARE, '1);
        cur_cfg = directed_rows[i].cfg_id;
        load_config(directed_config(cur_cfg));
      end
      send_item(directed_rows[i].op, directed_rows[i].value,
                directed_rows[i].known, directed_rows[i].result);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_for_idle();
      load_config(phase_config(phase));
      set_idle_mode(phase % 4);
      if (phase == PRESSURE_PHASE) holds_asked++;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        op = (r < 88) ? OP_FILTER : (r < 92) ? OP_CLEAR : (r < 96) ? OP_PRESET : OP_UNUSED;
        send_item(op, pick_sample(), 1'b0, '0);
        if (op != OP_UNUSED) counted++;
      end
    end

    wait_for_idle();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
